FILE: src/fqfc_pkg.sv
// Shared types, codes and limit arithmetic for the frame queue with flow control.
`timescale 1ns / 1ps

package fqfc_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int GOP_W     = 16;
    localparam int MARK_W    = 6;
    localparam int TYPE_W    = 8;
    localparam int LIM_W     = GOP_W + 1;

    localparam logic [GOP_W-1:0]  GOP_RESET    = 16'd30;
    localparam logic [MARK_W-1:0] HIGH_RESET   = 6'd25;
    localparam logic [MARK_W-1:0] MIDDLE_RESET = 6'd20;
    localparam logic [TYPE_W-1:0] SPS_RESET    = 8'd103;
    localparam logic [TYPE_W-1:0] PPS_RESET    = 8'd104;
    localparam logic [GOP_W-1:0]  DIST_MAX     = 16'hFFFF;

    // x / 5 as (x * DIV5_MULT) >> DIV5_SHIFT, exact for x below 2^19
    localparam int PROD_IN_W  = LIM_W + 2;
    localparam int PROD_W     = 2 * PROD_IN_W;
    localparam int DIV5_SHIFT = 21;
    localparam logic [PROD_IN_W-1:0] DIV5_MULT = 19'd419431;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DISCARDED = 3'd1,
        ST_FULL      = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FLUSHED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        WM_LOW  = 2'd0,
        WM_MID  = 2'd1,
        WM_HIGH = 2'd2
    } wm_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOP_LENGTH   = 3'd0,
        CFG_FLUENCY_MODE = 3'd1,
        CFG_HIGH_MARK    = 3'd2,
        CFG_MIDDLE_MARK  = 3'd3,
        CFG_SPS_TYPE     = 3'd4,
        CFG_PPS_TYPE     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        status_t status;
        wm_t     wm;
        logic    discarding;
    } result_t;

    function automatic logic [LIM_W-1:0] half_limit(input logic [GOP_W-1:0] gop);
        logic [LIM_W-1:0] sum;
        sum = {1'b0, gop} + LIM_W'(1);
        return sum >> 1;
    endfunction

    function automatic logic [LIM_W-1:0] four_fifths_limit(input logic [GOP_W-1:0] gop);
        logic [PROD_IN_W-1:0] scaled;
        logic [PROD_W-1:0]    prod;
        scaled = {({1'b0, gop} + LIM_W'(1)), 2'b00};
        prod   = {{PROD_IN_W{1'b0}}, scaled} * {{PROD_IN_W{1'b0}}, DIV5_MULT};
        return prod[DIV5_SHIFT +: LIM_W];
    endfunction

endpackage

FILE: src/fqfc_len_ram.sv
// Frame length store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module fqfc_len_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 21
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/frame_queue_flow_control.sv
// Top level: frame length ring with video-aware admission control.
//
// Input beats carry a command in s_tuser (push, pop, flush) and the frame's type
// byte and length in s_tdata. Every beat yields exactly one result beat on the
// m_ side: status in m_tuser, popped length, occupancy, watermark and discard
// flag in m_tdata.
// Accepted beats pass the stage register, then the result register; one beat is
// taken per cycle while m_tready keeps up, set by the single pass of pointer
// update and limit compares between the input port and the stage register. The
// length store is read on accept and its registered data feeds the result register.
// A stage register in front of the result register lets the block take a new
// beat while a result waits; when m_tready stays low both fill and s_tready
// drops until the result is taken.
// The user must write registers via cfg_we/cfg_addr/cfg_wdata only while the block
// is idle; the block does not enforce this. Reset (aresetn low, synchronous) empties
// the ring, clears the discard flag and key distance and loads register defaults.
// Length store contents are not cleared; only written entries are read back.
`timescale 1ns / 1ps

module frame_queue_flow_control #(
    parameter int QUEUE_SLOTS     = 32,
    parameter int MAX_FRAME_BYTES = 1048576,
    localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1),
    localparam int OCC_W  = $clog2(QUEUE_SLOTS),
    localparam int IN_W   = ((8 + LEN_W + 7) / 8) * 8,
    localparam int OUT_W  = ((LEN_W + OCC_W + 3 + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fqfc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [fqfc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // frame_type, frame_len, zero pad
    input  logic [1:0]                    s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,   // out_len, occupancy, watermark,
                                                     // discarding, zero pad
    output logic [2:0]                    m_tuser    // status
);

    import fqfc_pkg::*;

    localparam int PTR_W = OCC_W;
    localparam int CMP_W = (OCC_W > MARK_W) ? OCC_W : MARK_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);
    localparam logic [PTR_W-1:0] KEY_LIMIT = PTR_W'(QUEUE_SLOTS - 1);
    localparam logic [PTR_W-1:0] STD_LIMIT = PTR_W'(QUEUE_SLOTS - 2);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME_BYTES);

    logic [GOP_W-1:0]  gop_reg;
    logic              fluency_reg;
    logic [MARK_W-1:0] high_mark_reg;
    logic [MARK_W-1:0] middle_mark_reg;
    logic [TYPE_W-1:0] sps_reg;
    logic [TYPE_W-1:0] pps_reg;
    logic [LIM_W-1:0]  half_reg;
    logic [LIM_W-1:0]  ff_reg;

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              flag_reg, flag_next;
    logic [GOP_W-1:0]  dist_reg, dist_next;

    logic              st_valid_reg;
    result_t           st_res_reg, st_res_next;
    logic [OCC_W-1:0]  st_occ_reg, st_occ_next;

    logic              out_valid_reg;
    result_t           out_res_reg;
    logic [OCC_W-1:0]  out_occ_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic              s_acc;
    logic              advance;
    cmd_t              cmd;
    logic [TYPE_W-1:0] in_type;
    logic [LEN_W-1:0]  in_len;
    logic [LEN_W-1:0]  len_clamped;
    logic              ram_we;
    logic [LEN_W-1:0]  ram_q;

    logic              is_param;
    logic [GOP_W-1:0]  dist_inc;
    logic [PTR_W-1:0]  occ_cur;
    wm_t               wm_cur;
    logic              raise;
    logic              flag_mid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
        logic [PTR_W:0] sum;
        sum = {1'b0, w} + ((w < r) ? (PTR_W+1)'(QUEUE_SLOTS) : '0) - {1'b0, r};
        return sum[PTR_W-1:0];
    endfunction

    function automatic wm_t level_of(input logic [PTR_W-1:0] occ,
                                     input logic [MARK_W-1:0] hi,
                                     input logic [MARK_W-1:0] mid);
        logic [CMP_W-1:0] o;
        o = CMP_W'(occ);
        priority if (o >= CMP_W'(hi)) begin
            return WM_HIGH;
        end else if (o >= CMP_W'(mid)) begin
            return WM_MID;
        end else begin
            return WM_LOW;
        end
    endfunction

    assign cmd      = cmd_t'(s_tuser);
    assign in_type  = s_tdata[TYPE_W-1:0];
    assign in_len   = s_tdata[TYPE_W +: LEN_W];
    assign len_clamped = (in_len > LEN_MAX) ? LEN_MAX : in_len;

    assign advance  = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gop_reg         <= GOP_RESET;
            fluency_reg     <= 1'b0;
            high_mark_reg   <= HIGH_RESET;
            middle_mark_reg <= MIDDLE_RESET;
            sps_reg         <= SPS_RESET;
            pps_reg         <= PPS_RESET;
            half_reg        <= half_limit(GOP_RESET);
            ff_reg          <= four_fifths_limit(GOP_RESET);
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_GOP_LENGTH: begin
                    gop_reg  <= cfg_wdata[GOP_W-1:0];
                    half_reg <= half_limit(cfg_wdata[GOP_W-1:0]);
                    ff_reg   <= four_fifths_limit(cfg_wdata[GOP_W-1:0]);
                end
                CFG_FLUENCY_MODE: fluency_reg     <= cfg_wdata[0];
                CFG_HIGH_MARK:    high_mark_reg   <= cfg_wdata[MARK_W-1:0];
                CFG_MIDDLE_MARK:  middle_mark_reg <= cfg_wdata[MARK_W-1:0];
                CFG_SPS_TYPE:     sps_reg         <= cfg_wdata[TYPE_W-1:0];
                CFG_PPS_TYPE:     pps_reg         <= cfg_wdata[TYPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        flag_next   = flag_reg;
        dist_next   = dist_reg;
        ram_we      = 1'b0;
        st_res_next.status = ST_FLUSHED;

        is_param = (in_type == sps_reg) || (in_type == pps_reg);
        dist_inc = (dist_reg == DIST_MAX) ? dist_reg : dist_reg + GOP_W'(1);
        occ_cur  = fill_of(wr_ptr_reg, rd_ptr_reg);
        wm_cur   = level_of(occ_cur, high_mark_reg, middle_mark_reg);
        raise    = ((wm_cur == WM_HIGH) && ({1'b0, dist_inc} > half_reg)) ||
                   ((wm_cur == WM_MID) && ({1'b0, dist_inc} > ff_reg));
        flag_mid = raise ? fluency_reg : 1'b0;

        unique case (cmd)
            CMD_PUSH: begin
                if (is_param) begin
                    flag_next = 1'b0;
                    dist_next = '0;
                    if (occ_cur >= KEY_LIMIT) begin
                        st_res_next.status = ST_FULL;
                    end else begin
                        ram_we             = 1'b1;
                        wr_ptr_next        = ptr_inc(wr_ptr_reg);
                        st_res_next.status = ST_STORED;
                    end
                end else begin
                    dist_next = dist_inc;
                    if (flag_reg) begin
                        st_res_next.status = ST_DISCARDED;
                    end else if (occ_cur >= STD_LIMIT) begin
                        flag_next = flag_mid ? 1'b1 :
                                    (({1'b0, dist_inc} > half_reg) ? fluency_reg : 1'b0);
                        st_res_next.status = ST_FULL;
                    end else begin
                        flag_next          = flag_mid;
                        ram_we             = 1'b1;
                        wr_ptr_next        = ptr_inc(wr_ptr_reg);
                        st_res_next.status = ST_STORED;
                    end
                end
            end
            CMD_POP: begin
                if (wr_ptr_reg == rd_ptr_reg) begin
                    st_res_next.status = ST_EMPTY;
                end else begin
                    rd_ptr_next        = ptr_inc(rd_ptr_reg);
                    st_res_next.status = ST_POPPED;
                end
            end
            default: begin
                wr_ptr_next        = rd_ptr_reg;
                st_res_next.status = ST_FLUSHED;
            end
        endcase

        st_occ_next            = fill_of(wr_ptr_next, rd_ptr_next);
        st_res_next.wm         = level_of(st_occ_next, high_mark_reg, middle_mark_reg);
        st_res_next.discarding = flag_next;
    end

    fqfc_len_ram #(
        .DEPTH  (QUEUE_SLOTS),
        .ADDR_W (PTR_W),
        .DATA_W (LEN_W)
    ) u_len_ram (
        .aclk    (aclk),
        .wr_en   (s_acc && ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (len_clamped),
        .rd_en   (s_acc),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            flag_reg   <= 1'b0;
            dist_reg   <= '0;
        end else if (s_acc) begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            flag_reg   <= flag_next;
            dist_reg   <= dist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_acc) begin
            st_valid_reg <= 1'b1;
        end else if (advance) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st_res_reg <= st_res_next;
            st_occ_reg <= st_occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= st_res_reg;
            out_occ_reg <= st_occ_reg;
            out_len_reg <= (st_res_reg.status == ST_POPPED) ? ram_q : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = OUT_W'({out_res_reg.discarding, out_res_reg.wm, out_occ_reg, out_len_reg});

endmodule
